### design/cie_pkg.sv
// ----------------------------------------------------------------------------
// CPU interrupt edge latch package
// Event codes, bus widths and the interrupt state record.
// ----------------------------------------------------------------------------
package cie_pkg;

  localparam int unsigned OP_W       = 4;
  localparam int unsigned CLOCK_W    = 64;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_NMI_ASSERT = 4'd0,
    OP_NMI_CLEAR  = 4'd1,
    OP_NMI_FORCE  = 4'd2,
    OP_IRQ_ASSERT = 4'd3,
    OP_IRQ_CLEAR  = 4'd4,
    OP_IRQ_STATUS = 4'd5,
    OP_IRQ_CANCEL = 4'd6,
    OP_IRQ_FORCE  = 4'd7,
    OP_OBSERVE    = 4'd8,
    OP_EDGE       = 4'd9,
    OP_TAKE_NMI   = 4'd10,
    OP_TAKE_IRQ   = 4'd11,
    OP_LOCK       = 4'd12,
    OP_UNLOCK     = 4'd13
  } opcode_t;

  typedef struct packed {
    logic               nmi_level;
    logic               nmi_seen;
    logic               nmi_armed;
    logic               nmi_req;
    logic               irq_level;
    logic               irq_skip;
    logic               irq_armed;
    logic               irq_req;
    logic               observe_lock;
    logic [CLOCK_W-1:0] nmi_stamp;
    logic [CLOCK_W-1:0] irq_stamp;
  } irq_state_t;

endpackage

### design/cpu_interrupt_edge_latch.sv
// ----------------------------------------------------------------------------
// CPU interrupt edge latch
// NMI edge latch and IRQ level latch driven by a stream of timed events.
// ----------------------------------------------------------------------------
// Each input item is one event: in_tuser carries the event code and in_tdata
// the master clock and the interrupt disable flag. Each item produces exactly
// one result item on the out_ channel, holding the taken flag and the full
// set of interrupt flags after the event has been applied.
// An item is first captured in an input register; when it moves on, the
// event is applied to the interrupt state and the result is loaded into the
// output register. One item is accepted per cycle while the receiver takes
// results; each item passes through the single state update with its
// 64-bit timestamp compare.
// When the receiver stalls, the result waits in the output register while
// the input register takes one further item; input is then held off.
// Reset clears every flag, both timestamps and both valid stages.
// ----------------------------------------------------------------------------
module cpu_interrupt_edge_latch (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: event_clock[63:0], irq_mask, zero fill.
  input  logic [cie_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields from bit 0: opcode.
  input  logic [cie_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: taken, nmi_level, nmi_seen, nmi_armed, nmi_req,
  // irq_level, irq_skip, irq_armed, irq_req, lock, zero fill.
  output logic [cie_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import cie_pkg::*;

  logic               s1_valid_r;
  opcode_t            s1_op_r;
  logic [CLOCK_W-1:0] s1_clock_r;
  logic               s1_disabled_r;
  logic               advance;
  irq_state_t         state_r;
  irq_state_t         state_nxt;
  logic               taken_nxt;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    state_nxt = state_r;
    taken_nxt = 1'b0;
    case (s1_op_r)
      OP_NMI_ASSERT: begin
        if (!state_r.nmi_level) begin
          state_nxt.nmi_seen = 1'b1;
        end
        state_nxt.nmi_level = 1'b1;
      end
      OP_NMI_CLEAR: state_nxt.nmi_level = 1'b0;
      OP_NMI_FORCE: begin
        state_nxt.nmi_armed = 1'b1;
        state_nxt.nmi_stamp = '0;
      end
      OP_IRQ_ASSERT: begin
        if (!state_r.irq_level) begin
          state_nxt.irq_skip = 1'b1;
        end
        state_nxt.irq_level = 1'b1;
      end
      OP_IRQ_CLEAR: state_nxt.irq_level = 1'b0;
      OP_IRQ_STATUS: begin
        state_nxt.irq_level = 1'b0;
        state_nxt.irq_skip  = 1'b0;
        state_nxt.irq_armed = 1'b0;
      end
      OP_IRQ_CANCEL: begin
        state_nxt.irq_level = 1'b0;
        state_nxt.irq_skip  = 1'b0;
        state_nxt.irq_armed = 1'b0;
        state_nxt.irq_req   = 1'b0;
      end
      OP_IRQ_FORCE: begin
        state_nxt.irq_armed = 1'b1;
        state_nxt.irq_stamp = '0;
      end
      OP_OBSERVE: begin
        if (state_r.nmi_seen) begin
          state_nxt.nmi_seen  = 1'b0;
          state_nxt.nmi_armed = 1'b1;
          state_nxt.nmi_stamp = s1_clock_r;
        end
        if (state_r.irq_skip) begin
          state_nxt.irq_skip = 1'b0;
        end else if (state_r.irq_level) begin
          if (!state_r.irq_armed) begin
            state_nxt.irq_stamp = s1_clock_r;
          end
          state_nxt.irq_armed = 1'b1;
        end
      end
      OP_EDGE: begin
        if (!state_r.observe_lock) begin
          if (state_r.nmi_armed && (state_r.nmi_stamp <= s1_clock_r)) begin
            state_nxt.nmi_req   = 1'b1;
            state_nxt.nmi_armed = 1'b0;
          end
          if (state_r.irq_armed && (state_r.irq_stamp <= s1_clock_r)) begin
            if (!s1_disabled_r) begin
              state_nxt.irq_req = 1'b1;
            end
            state_nxt.irq_armed = 1'b0;
          end
        end
      end
      OP_TAKE_NMI: begin
        taken_nxt         = state_r.nmi_req;
        state_nxt.nmi_req = 1'b0;
      end
      OP_TAKE_IRQ: begin
        taken_nxt         = state_r.irq_req;
        state_nxt.irq_req = 1'b0;
      end
      OP_LOCK:   state_nxt.observe_lock = 1'b1;
      OP_UNLOCK: state_nxt.observe_lock = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r       <= opcode_t'(in_tuser);
      s1_clock_r    <= in_tdata[CLOCK_W-1:0];
      s1_disabled_r <= in_tdata[CLOCK_W];
    end
    if (advance) begin
      out_data_r <= {6'b0, state_nxt.observe_lock, state_nxt.irq_req,
                     state_nxt.irq_armed, state_nxt.irq_skip,
                     state_nxt.irq_level, state_nxt.nmi_req,
                     state_nxt.nmi_armed, state_nxt.nmi_seen,
                     state_nxt.nmi_level, taken_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_advance_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("Advancing item did not reach the output register.");

  a_take_nmi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_op_r == OP_TAKE_NMI) |=> !state_r.nmi_req)
    else $error("NMI still pending after it was taken.");

  a_lock_freezes_edge: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_op_r == OP_EDGE) && state_r.observe_lock |=> $stable(state_r))
    else $error("Locked opcode edge changed the interrupt state.");

  a_no_load_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r && !out_valid_r |=> !out_valid_r)
    else $error("Result appeared without an item in flight.");

endmodule
